[design/ppm_pkg.sv]
// Shared types, widths and constants of the photon pixel mapper.
package ppm_pkg;

  localparam int MARK_WIDTH      = 8;
  localparam int CHAN_WIDTH      = 7;
  localparam int FINE_WIDTH      = 16;
  localparam int X_WIDTH         = 21;
  localparam int LINE_WIDTH      = 17;
  localparam int PIX_WIDTH       = 13;
  localparam int CFG_DATA_WIDTH  = 32;
  localparam int CFG_INDEX_WIDTH = 3;
  localparam int QUEUE_DEPTH     = 4;

  // Quotient bits of the scaling divider; anything at or above 2^22 saturates.
  localparam int QUOT_BITS = 23;
  localparam int CNT_WIDTH = $clog2(QUOT_BITS);
  localparam int X_CAP     = 1 << 22;

  localparam logic signed [LINE_WIDTH-1:0] LINE_MAX = 17'sd65535;
  localparam logic signed [PIX_WIDTH-1:0]  PIX_MAX  = 13'sd4095;
  localparam logic signed [X_WIDTH-1:0]    X_MAX    = 21'sh0FFFFF;
  localparam logic signed [X_WIDTH-1:0]    X_MIN    = 21'sh100000;

  typedef enum logic [CFG_INDEX_WIDTH-1:0] {
    REG_MARKER_MASKS     = 3'd0,
    REG_LINE_DURATION    = 3'd1,
    REG_INTERLINE_PERIOD = 3'd2,
    REG_PIXELS_PER_LINE  = 3'd3,
    REG_MIRROR_PHASE     = 3'd4,
    REG_FLIP_MODE        = 3'd5,
    REG_FRAME_INDEX      = 3'd6
  } reg_index_t;

  typedef struct packed {
    logic [31:0]                marker_masks;
    logic [31:0]                line_duration;
    logic [31:0]                interline_period;
    logic [PIX_WIDTH-1:0]       pixels_per_line;
    logic signed [X_WIDTH-1:0]  mirror_phase;
    logic [1:0]                 flip_mode;
    logic [15:0]                frame_index;
  } cfg_t;

  // Width of one queue word between the front and the back end.
  function automatic int entry_width(input int tw);
    return PIX_WIDTH + LINE_WIDTH + 2 * tw + CHAN_WIDTH + FINE_WIDTH;
  endfunction

endpackage

[design/ppm_if.sv]
// Handshake interfaces for the event, result and configuration channels.
interface ppm_event_if #(parameter int TIME_WIDTH = 48);
  import ppm_pkg::*;
  logic                  valid;
  logic                  ready;
  logic [MARK_WIDTH-1:0] event_mark;
  logic [TIME_WIDTH-1:0] arrival_time;
  logic [FINE_WIDTH-1:0] fine_time;
  logic [CHAN_WIDTH-1:0] detector_channel;
  modport source (output valid, event_mark, arrival_time, fine_time, detector_channel,
                  input ready);
  modport sink (input valid, event_mark, arrival_time, fine_time, detector_channel,
                output ready);
endinterface

interface ppm_result_if #(parameter int TIME_WIDTH = 48);
  import ppm_pkg::*;
  logic                         valid;
  logic                         ready;
  logic signed [X_WIDTH-1:0]    x_position;
  logic signed [LINE_WIDTH-1:0] line_number;
  logic [CHAN_WIDTH-1:0]        photon_channel;
  logic [FINE_WIDTH-1:0]        photon_fine_time;
  logic [TIME_WIDTH-1:0]        photon_arrival;
  modport source (output valid, x_position, line_number, photon_channel, photon_fine_time,
                  photon_arrival, input ready);
  modport sink (input valid, x_position, line_number, photon_channel, photon_fine_time,
                photon_arrival, output ready);
endinterface

interface ppm_cfg_if;
  import ppm_pkg::*;
  logic                       valid;
  logic                       ready;
  logic [CFG_INDEX_WIDTH-1:0] index;
  logic [CFG_DATA_WIDTH-1:0]  data;
  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

[design/ppm_regs.sv]
// Configuration register file of the photon pixel mapper.
module ppm_regs (
  input  logic          clk,
  input  logic          rst,
  ppm_cfg_if.sink       cfg,
  output ppm_pkg::cfg_t regs
);
  import ppm_pkg::*;

  assign cfg.ready = !rst;

  always_ff @(posedge clk) begin
    if (rst) begin
      regs.marker_masks     <= '0;
      regs.line_duration    <= 32'd1;
      regs.interline_period <= '0;
      regs.pixels_per_line  <= 13'd256;
      regs.mirror_phase     <= '0;
      regs.flip_mode        <= '0;
      regs.frame_index      <= '0;
    end else if (cfg.valid) begin
      case (cfg.index)
        REG_MARKER_MASKS:     regs.marker_masks <= cfg.data;
        REG_LINE_DURATION:    regs.line_duration <= cfg.data;
        REG_INTERLINE_PERIOD: regs.interline_period <= cfg.data;
        REG_PIXELS_PER_LINE:  regs.pixels_per_line <= cfg.data[PIX_WIDTH-1:0];
        REG_MIRROR_PHASE:     regs.mirror_phase <= $signed(cfg.data[X_WIDTH-1:0]);
        REG_FLIP_MODE:        regs.flip_mode <= cfg.data[1:0];
        REG_FRAME_INDEX:      regs.frame_index <= cfg.data[15:0];
        default: ;
      endcase
    end
  end

endmodule

[design/ppm_front.sv]
// Front end: decodes marker bits, tracks line and pixel state, queues photon words.
module ppm_front #(
  parameter int TIME_WIDTH = 48
) (
  input  logic                                        clk,
  input  logic                                        rst,
  ppm_event_if.sink                                   events,
  input  ppm_pkg::cfg_t                               regs,
  input  logic                                        q_full,
  output logic                                        q_push,
  output logic [ppm_pkg::entry_width(TIME_WIDTH)-1:0] q_data
);
  import ppm_pkg::*;

  logic signed [LINE_WIDTH-1:0] line_count;
  logic signed [LINE_WIDTH-1:0] line_count_next;
  logic signed [PIX_WIDTH-1:0]  pixel_count;
  logic signed [PIX_WIDTH-1:0]  pixel_count_next;
  logic signed [PIX_WIDTH-1:0]  pixel_base;
  logic [TIME_WIDTH-1:0]        line_origin;
  logic [TIME_WIDTH-1:0]        line_origin_next;
  logic                         line_open;
  logic                         line_open_next;
  logic [TIME_WIDTH-1:0]        diff;
  logic                         hit_start;
  logic                         hit_end;
  logic                         hit_pix;
  logic                         closing;
  logic                         starting;
  logic                         photon;
  logic                         accept;

  assign events.ready = !rst && !q_full;
  assign accept       = events.valid && events.ready;

  always_comb begin
    hit_start = |(events.event_mark & regs.marker_masks[7:0]);
    hit_end   = |(events.event_mark & regs.marker_masks[15:8]);
    hit_pix   = |(events.event_mark & regs.marker_masks[23:16]);
    photon    = events.event_mark == regs.marker_masks[31:24];

    // A line end only counts while a line is open, and then it masks a start.
    closing  = hit_end && line_open;
    starting = !closing && hit_start;

    line_open_next = closing ? 1'b0 : (starting ? 1'b1 : line_open);
    line_origin_next = starting ? events.arrival_time : line_origin;
    line_count_next = (starting && line_count != LINE_MAX) ? line_count + 17'sd1 : line_count;

    pixel_base = starting ? '1 : pixel_count;
    pixel_count_next = (hit_pix && pixel_base != PIX_MAX) ? pixel_base + 13'sd1 : pixel_base;

    diff = events.arrival_time - line_origin_next;
  end

  assign q_push = accept && photon;
  assign q_data = {pixel_count_next, line_count_next, diff, events.detector_channel,
                   events.fine_time, events.arrival_time};

  always_ff @(posedge clk) begin
    if (rst) begin
      line_count  <= '1;
      pixel_count <= '1;
      line_origin <= '0;
      line_open   <= 1'b0;
    end else if (accept) begin
      line_count  <= line_count_next;
      pixel_count <= pixel_count_next;
      line_origin <= line_origin_next;
      line_open   <= line_open_next;
    end
  end

endmodule

[design/ppm_fifo.sv]
// Short word queue between the front and the back end.
module ppm_fifo #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 4
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             push,
  input  logic [WIDTH-1:0] push_data,
  input  logic             pop,
  output logic [WIDTH-1:0] pop_data,
  output logic             full,
  output logic             empty
);
  localparam int PTR_W = $clog2(DEPTH);
  localparam int CNT_W = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] count;

  assign full     = count == CNT_W'(DEPTH);
  assign empty    = count == '0;
  assign pop_data = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

  a_no_overflow: assert property (@(posedge clk) disable iff (rst) full |-> !push)
    else $error("word pushed into a full queue");
  a_count_range: assert property (@(posedge clk) disable iff (rst) count <= CNT_W'(DEPTH))
    else $error("queue fill count out of range");
  a_pop_nonempty: assert property (@(posedge clk) disable iff (rst) empty |-> !pop)
    else $error("word popped from an empty queue");

endmodule

[design/ppm_back.sv]
// Back end: line wraparound, time-to-pixel scaling by a serial divider, mirroring.
module ppm_back #(
  parameter int TIME_WIDTH  = 48,
  parameter int X_FRAC_BITS = 8
) (
  input  logic                                        clk,
  input  logic                                        rst,
  input  ppm_pkg::cfg_t                               regs,
  input  logic                                        q_empty,
  input  logic [ppm_pkg::entry_width(TIME_WIDTH)-1:0] q_data,
  output logic                                        q_pop,
  ppm_result_if.source                                results
);
  import ppm_pkg::*;

  localparam int MW   = PIX_WIDTH + X_FRAC_BITS;
  localparam int PW   = TIME_WIDTH + MW;
  localparam int HL   = TIME_WIDTH / 2;
  localparam int HH   = TIME_WIDTH - HL;
  localparam int XW   = (((14 + X_FRAC_BITS) > 24) ? (14 + X_FRAC_BITS) : 24) + 2;

  typedef enum logic [2:0] {
    S_IDLE, S_MUL_LO, S_MUL_HI, S_CHECK, S_DIV, S_FIN
  } state_t;

  state_t state;

  // Queue word fields.
  logic signed [PIX_WIDTH-1:0]  e_pix;
  logic signed [LINE_WIDTH-1:0] e_line;
  logic [TIME_WIDTH-1:0]        e_diff;
  logic [CHAN_WIDTH-1:0]        e_chan;
  logic [FINE_WIDTH-1:0]        e_fine;
  logic [TIME_WIDTH-1:0]        e_arr;

  assign {e_pix, e_line, e_diff, e_chan, e_fine, e_arr} = q_data;

  // Per-item working registers.
  logic [TIME_WIDTH-1:0]        mag;
  logic                         neg;
  logic [PW-1:0]                acc;
  logic [31:0]                  rem;
  logic [QUOT_BITS-1:0]         quot;
  logic [QUOT_BITS-1:0]         plo;
  logic                         sat;
  logic [CNT_WIDTH-1:0]         cnt;
  logic signed [PIX_WIDTH-1:0]  pix_reg;
  logic signed [LINE_WIDTH-1:0] line_reg;
  logic                         odd_reg;
  logic [CHAN_WIDTH-1:0]        chan_reg;
  logic [FINE_WIDTH-1:0]        fine_reg;
  logic [TIME_WIDTH-1:0]        arr_reg;

  // Output register.
  logic                         res_valid;
  logic signed [X_WIDTH-1:0]    res_x;
  logic signed [LINE_WIDTH-1:0] res_line;
  logic [CHAN_WIDTH-1:0]        res_chan;
  logic [FINE_WIDTH-1:0]        res_fine;
  logic [TIME_WIDTH-1:0]        res_arr;

  logic [31:0]                  l_eff;
  logic [MW-1:0]                m_val;
  logic                         pix_mode;
  logic [32:0]                  half_sum;
  logic [TIME_WIDTH-1:0]        inter_t;
  logic                         late;
  logic                         below;
  logic [TIME_WIDTH-1:0]        mag_next;
  logic signed [LINE_WIDTH:0]   photon_line;
  logic signed [LINE_WIDTH-1:0] line_sat;
  logic                         odd;
  logic [HL+MW-1:0]             prod_lo;
  logic [HH+MW-1:0]             prod_hi;
  logic [32:0]                  r2;
  logic [32:0]                  r2_diff;
  logic                         ge;
  logic signed [XW-1:0]         v_mag;
  logic signed [XW-1:0]         x_time;
  logic signed [XW-1:0]         x_pix;
  logic signed [XW-1:0]         x_base;
  logic signed [XW-1:0]         ppl_one;
  logic signed [XW-1:0]         x_flip;
  logic signed [XW-1:0]         x_fin;
  logic signed [X_WIDTH-1:0]    x_out;
  logic                         flip;
  logic                         out_free;

  always_comb begin
    l_eff    = (regs.line_duration == '0) ? 32'd1 : regs.line_duration;
    m_val    = MW'(regs.pixels_per_line) << X_FRAC_BITS;
    pix_mode = regs.marker_masks[23:16] != '0;

    // In time mode, photons past the midpoint between lines belong to the next line.
    half_sum = {1'b0, regs.interline_period} + {1'b0, l_eff};
    inter_t  = TIME_WIDTH'(regs.interline_period);
    late     = !pix_mode && (e_diff > TIME_WIDTH'(half_sum[32:1]));
    below    = e_diff < inter_t;
    if (!late) begin
      mag_next = e_diff;
    end else if (below) begin
      mag_next = inter_t - e_diff;
    end else begin
      mag_next = e_diff - inter_t;
    end

    photon_line = (LINE_WIDTH + 1)'(e_line) + {{LINE_WIDTH{1'b0}}, late};
    line_sat  = (photon_line > (LINE_WIDTH + 1)'(LINE_MAX)) ? LINE_MAX
                                                            : photon_line[LINE_WIDTH-1:0];
    // Line -1 and line 0 never count as odd; parity uses the unsaturated index.
    odd = !photon_line[LINE_WIDTH] && photon_line[0];

    prod_lo = mag[HL-1:0] * m_val;
    prod_hi = mag[TIME_WIDTH-1:HL] * m_val;

    r2      = {rem, plo[QUOT_BITS-1]};
    r2_diff = r2 - {1'b0, l_eff};
    ge      = r2 >= {1'b0, l_eff};

    v_mag  = (sat || quot > QUOT_BITS'(X_CAP)) ? XW'(X_CAP) : XW'(quot);
    x_time = neg ? -v_mag : v_mag;
    x_pix  = XW'(pix_reg) <<< X_FRAC_BITS;
    x_base = pix_mode ? x_pix : x_time;

    ppl_one = (XW'(regs.pixels_per_line) - XW'(1)) <<< X_FRAC_BITS;
    x_flip  = ppl_one - x_base - XW'(regs.mirror_phase);
    flip    = (regs.flip_mode[0] && odd_reg) || (regs.flip_mode[1] && regs.frame_index[0]);
    x_fin   = flip ? x_flip : x_base;

    if (x_fin > XW'(X_MAX)) begin
      x_out = X_MAX;
    end else if (x_fin < XW'(X_MIN)) begin
      x_out = X_MIN;
    end else begin
      x_out = x_fin[X_WIDTH-1:0];
    end

    out_free = !res_valid || results.ready;
  end

  assign q_pop = (state == S_IDLE) && !q_empty;

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      res_valid <= 1'b0;
    end else begin
      if (results.ready && !(state == S_FIN && out_free)) begin
        res_valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (!q_empty) begin
            mag      <= mag_next;
            neg      <= late && below;
            pix_reg  <= e_pix;
            line_reg <= line_sat;
            odd_reg  <= odd;
            chan_reg <= e_chan;
            fine_reg <= e_fine;
            arr_reg  <= e_arr;
            state    <= pix_mode ? S_FIN : S_MUL_LO;
          end
        end
        S_MUL_LO: begin
          acc   <= PW'(prod_lo);
          state <= S_MUL_HI;
        end
        S_MUL_HI: begin
          acc   <= acc + (PW'(prod_hi) << HL);
          state <= S_CHECK;
        end
        S_CHECK: begin
          // A quotient of 2^23 or more is flagged as saturated.
          sat   <= acc[PW-1:QUOT_BITS] >= l_eff;
          rem   <= 32'(acc[PW-1:QUOT_BITS]);
          plo   <= acc[QUOT_BITS-1:0];
          quot  <= '0;
          cnt   <= '0;
          state <= S_DIV;
        end
        S_DIV: begin
          rem  <= ge ? r2_diff[31:0] : r2[31:0];
          quot <= {quot[QUOT_BITS-2:0], ge};
          plo  <= plo << 1;
          cnt  <= cnt + 1'b1;
          if (cnt == CNT_WIDTH'(QUOT_BITS - 1)) begin
            state <= S_FIN;
          end
        end
        S_FIN: begin
          if (out_free) begin
            res_valid <= 1'b1;
            res_x     <= x_out;
            res_line  <= line_reg;
            res_chan  <= chan_reg;
            res_fine  <= fine_reg;
            res_arr   <= arr_reg;
            state     <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  assign results.valid            = res_valid;
  assign results.x_position       = res_x;
  assign results.line_number      = res_line;
  assign results.photon_channel   = res_chan;
  assign results.photon_fine_time = res_fine;
  assign results.photon_arrival   = res_arr;

  a_pop_ok: assert property (@(posedge clk) disable iff (rst) q_pop |-> !q_empty)
    else $error("back end popped an empty queue");
  a_rem_below: assert property (@(posedge clk) disable iff (rst)
                                (state == S_DIV && !sat) |-> rem < l_eff)
    else $error("divider remainder not below the line duration");
  a_hold_result: assert property (@(posedge clk) disable iff (rst)
                                  (state == S_FIN && res_valid && !results.ready)
                                  |=> (state == S_FIN && res_valid))
    else $error("result word overwritten before it was taken");

endmodule

[design/photon_pixel_mapper_core.sv]
// Top level of the photon pixel mapper: registers, front end, queue and back end.
// Events without a photon mark are taken one per cycle while the four-word queue has room.
// Photon words in time mode pass through a split multiply and the 23-step serial divider
// in the back end; with pixel markers in use they skip both. The back end takes one word
// at a time and holds a finished result until the result channel can take it.
// Synchronous reset restores register defaults, line -1, pixel -1 and an empty queue.
module photon_pixel_mapper_core #(
  parameter int TIME_WIDTH  = 48,
  parameter int X_FRAC_BITS = 8
) (
  input  logic          clk,
  input  logic          rst,
  ppm_event_if.sink     events,
  ppm_result_if.source  results,
  ppm_cfg_if.sink       cfg
);
  import ppm_pkg::*;

  localparam int EW = entry_width(TIME_WIDTH);

  cfg_t          regs;
  logic          q_push;
  logic          q_pop;
  logic          q_full;
  logic          q_empty;
  logic [EW-1:0] q_in;
  logic [EW-1:0] q_out;

  ppm_regs u_regs (
    .clk  (clk),
    .rst  (rst),
    .cfg  (cfg),
    .regs (regs)
  );

  ppm_front #(
    .TIME_WIDTH (TIME_WIDTH)
  ) u_front (
    .clk    (clk),
    .rst    (rst),
    .events (events),
    .regs   (regs),
    .q_full (q_full),
    .q_push (q_push),
    .q_data (q_in)
  );

  ppm_fifo #(
    .WIDTH (EW),
    .DEPTH (QUEUE_DEPTH)
  ) u_fifo (
    .clk       (clk),
    .rst       (rst),
    .push      (q_push),
    .push_data (q_in),
    .pop       (q_pop),
    .pop_data  (q_out),
    .full      (q_full),
    .empty     (q_empty)
  );

  ppm_back #(
    .TIME_WIDTH  (TIME_WIDTH),
    .X_FRAC_BITS (X_FRAC_BITS)
  ) u_back (
    .clk     (clk),
    .rst     (rst),
    .regs    (regs),
    .q_empty (q_empty),
    .q_data  (q_out),
    .q_pop   (q_pop),
    .results (results)
  );

endmodule
